/* sv/assert_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define SCTA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication.
`define SCTA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SCTA_ASSERT_IMP(label, clk, rst, ante, cons)
`define SCTA_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/scta_pkg.sv */
package scta_pkg;

   localparam int TIME_BITS  = 16;
   localparam int CHAN_W     = 4;
   localparam int HIT_W      = 4;
   localparam int MEAN_W     = 17;
   localparam int COUNT_W    = 4;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   // Register indexes.
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_LOW  = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_WINDOW_HIGH = 1'd1;

   localparam logic [TIME_BITS-1:0] WINDOW_LOW_RESET  = 16'h0000;
   localparam logic [TIME_BITS-1:0] WINDOW_HIGH_RESET = 16'hFFFF;

   // Stages between a keep-pass read and its accumulation.
   localparam int KEEP_LAT = 4;

   typedef struct packed {
      logic [CHAN_W-1:0]    channel;
      logic [HIT_W-1:0]     hit_index;
      logic [TIME_BITS-1:0] hit_time;
      logic                 event_end;
   } req_type;

   typedef struct packed {
      logic signed [MEAN_W-1:0] clipped_mean;
      logic [COUNT_W-1:0]       used_count;
      logic [COUNT_W-1:0]       kept_count;
   } rsp_type;

   typedef struct packed {
      logic clear_sum;
      logic rd_sum;
      logic calc_nq;
      logic calc_spread;
      logic calc_lim;
      logic clear_keep;
      logic rd_keep;
      logic div_load;
      logic div_step;
      logic clear_store;
      logic load_out;
   } ctl_cmd_type;

endpackage

/* sv/sigma_clipped_clock_time_average.sv */
// Hits without the end mark are taken one per cycle and stored per channel.
// An end-of-event hit starts a pass over the channels for sums, a second pass
// through a 4-stage keep test, then a bit-serial divide of TIME_BITS+clog2 bits;
// rsp_valid rises once the divide ends and the output register is free.
// No hit is taken during that work; one may be taken while a result waits.
// Synchronous reset clears the store, sets the window to 0..65535, no result pending.
`include "assert_macros.svh"

module sigma_clipped_clock_time_average #(
   parameter int CHANNELS  = 14,
   parameter int HITS_USED = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  scta_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output scta_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [scta_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [scta_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   scta_pkg::ctl_cmd_type cmd;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  req_accept;

   assign req_accept = req_valid && req_ready;

   scta_ctrl #(
      .CHANNELS (CHANNELS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_end   (req_data.event_end),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .rd_addr   (rd_addr)
   );

   scta_dp #(
      .CHANNELS  (CHANNELS),
      .HITS_USED (HITS_USED)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_accept (req_accept),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .rd_addr    (rd_addr),
      .rsp_data   (rsp_data)
   );

   `SCTA_ASSERT_NXT(a_end_stalls_input, clock, reset, req_accept && req_data.event_end, !req_ready)
   `SCTA_ASSERT_IMP(a_result_after_work, clock, reset, $rose(rsp_valid), $past(!req_ready))

endmodule

/* sv/scta_ctrl.sv */
module scta_ctrl #(
   parameter int CHANNELS = 14
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_end,
   output logic                                  req_ready,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output scta_pkg::ctl_cmd_type                 cmd,
   output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int N_W    = $clog2(CHANNELS + 1);
   localparam int S_W    = scta_pkg::TIME_BITS + N_W;
   localparam int CNT_W  = $clog2(((CHANNELS > S_W) ? CHANNELS : S_W) + 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_SUM_DRAIN,
      ST_NQ,
      ST_SPREAD,
      ST_LIM,
      ST_KEEP,
      ST_KEEP_DRAIN,
      ST_DIV_START,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   logic             out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rd_addr   = cnt_ff[ADDR_W-1:0];
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // set on a new result, hold while the consumer stalls, drop once taken
   assign rsp_valid_in = ((state_ff == ST_DONE) && out_free) || (rsp_valid_ff && !rsp_ready);

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:       cmd.clear_sum = req_valid && req_end;
         ST_SUM:        cmd.rd_sum = 1'b1;
         ST_NQ:         cmd.calc_nq = 1'b1;
         ST_SPREAD:     cmd.calc_spread = 1'b1;
         ST_LIM: begin
            cmd.calc_lim   = 1'b1;
            cmd.clear_keep = 1'b1;
         end
         ST_KEEP:       cmd.rd_keep = 1'b1;
         ST_DIV_START: begin
            cmd.div_load    = 1'b1;
            cmd.clear_store = 1'b1;
         end
         ST_DIV:        cmd.div_step = 1'b1;
         ST_DONE:       cmd.load_out = out_free;
         default:       cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (req_valid && req_end) begin
                  state_ff <= ST_SUM;
                  cnt_ff   <= '0;
               end
            end
            ST_SUM: begin
               if (cnt_ff == CNT_W'(CHANNELS - 1)) begin
                  state_ff <= ST_SUM_DRAIN;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_SUM_DRAIN:  state_ff <= ST_NQ;
            ST_NQ:         state_ff <= ST_SPREAD;
            ST_SPREAD:     state_ff <= ST_LIM;
            ST_LIM: begin
               state_ff <= ST_KEEP;
               cnt_ff   <= '0;
            end
            ST_KEEP: begin
               if (cnt_ff == CNT_W'(CHANNELS - 1)) begin
                  state_ff <= ST_KEEP_DRAIN;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_KEEP_DRAIN: begin
               // wait for the last read to reach the keep accumulator
               if (cnt_ff == CNT_W'(scta_pkg::KEEP_LAT - 1)) begin
                  state_ff <= ST_DIV_START;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV;
               cnt_ff   <= '0;
            end
            ST_DIV: begin
               if (cnt_ff == CNT_W'(S_W - 1)) begin
                  state_ff <= ST_DONE;
                  cnt_ff   <= '0;
               end else begin
                  cnt_ff <= cnt_ff + 1'b1;
               end
            end
            ST_DONE: begin
               // hold the result until the output register is free
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

/* sv/scta_dp.sv */
module scta_dp #(
   parameter int CHANNELS  = 14,
   parameter int HITS_USED = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_accept,
   input  scta_pkg::req_type                     req_data,
   input  logic                                  csr_we,
   input  logic [scta_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [scta_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  scta_pkg::ctl_cmd_type                 cmd,
   input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_addr,
   output scta_pkg::rsp_type                     rsp_data
);

   localparam int T_W    = scta_pkg::TIME_BITS;
   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int N_W    = $clog2(CHANNELS + 1);
   localparam int S_W    = T_W + N_W;
   localparam int SQ_W   = 2 * T_W;
   localparam int Q_W    = 2 * T_W + N_W;
   localparam int P_W    = 2 * S_W;
   localparam int L_W    = P_W + 4;

   // window registers
   logic [T_W-1:0] win_lo_ff;
   logic [T_W-1:0] win_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_lo_ff <= scta_pkg::WINDOW_LOW_RESET;
         win_hi_ff <= scta_pkg::WINDOW_HIGH_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            scta_pkg::REG_WINDOW_LOW:  win_lo_ff <= csr_wdata;
            scta_pkg::REG_WINDOW_HIGH: win_hi_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // per-channel selection store
   logic [T_W-1:0]    sel_mem [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   logic [T_W-1:0]    rd_data_ff;
   logic              rd_vld_ff;
   logic              hit_take;
   logic [ADDR_W-1:0] wr_addr;

   assign wr_addr  = ADDR_W'(req_data.channel);
   assign hit_take = req_accept
                     && (32'(req_data.channel) < CHANNELS)
                     && (32'(req_data.hit_index) < HITS_USED)
                     && (req_data.hit_time >= win_lo_ff)
                     && (req_data.hit_time <= win_hi_ff);

   always_ff @(posedge clock) begin
      if (hit_take) begin
         sel_mem[wr_addr] <= req_data.hit_time;
      end
      rd_data_ff <= sel_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_store) begin
         vld_ff <= '0;
      end else if (hit_take) begin
         vld_ff[wr_addr] <= 1'b1;
      end
      rd_vld_ff <= vld_ff[rd_addr];
   end

   logic x_nz;
   assign x_nz = rd_vld_ff && (rd_data_ff != '0);

   // pass one: sum, sum of squares, count
   logic           tag_sum_ff;
   logic [S_W-1:0] s_ff;
   logic [Q_W-1:0] q_ff;
   logic [N_W-1:0] n_ff;
   logic [2*T_W-1:0] sq_w;

   assign sq_w = SQ_W'(rd_data_ff) * SQ_W'(rd_data_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_sum_ff <= 1'b0;
      end else begin
         tag_sum_ff <= cmd.rd_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_sum) begin
         s_ff <= '0;
         q_ff <= '0;
         n_ff <= '0;
      end else if (tag_sum_ff && x_nz) begin
         s_ff <= s_ff + S_W'(rd_data_ff);
         q_ff <= q_ff + Q_W'(sq_w);
         n_ff <= n_ff + 1'b1;
      end
   end

   // spread and threshold: 9 * (n*Q - S*S)
   logic [P_W-1:0] nq_w;
   logic [P_W-1:0] ss_w;
   logic [P_W-1:0] nq_ff;
   logic [P_W-1:0] ss_ff;
   logic [P_W-1:0] spread_ff;
   logic [L_W-1:0] lim_w;
   logic [L_W-1:0] lim_ff;

   assign nq_w  = P_W'(n_ff) * P_W'(q_ff);
   assign ss_w  = P_W'(s_ff) * P_W'(s_ff);
   assign lim_w = (L_W'(spread_ff) << 3) + L_W'(spread_ff);

   always_ff @(posedge clock) begin
      if (cmd.calc_nq) begin
         nq_ff <= nq_w;
         ss_ff <= ss_w;
      end
      if (cmd.calc_spread) begin
         spread_ff <= nq_ff - ss_ff;
      end
      if (cmd.calc_lim) begin
         lim_ff <= lim_w;
      end
   end

   // pass two: keep test pipeline
   logic           tag_keep_ff;
   logic           vb_ff, vc_ff, vd_ff;
   logic [T_W-1:0] xb_ff, xc_ff, xd_ff;
   logic [S_W-1:0] nx_w;
   logic [S_W-1:0] nx_ff;
   logic [S_W-1:0] d_ff;
   logic [P_W-1:0] dd_w;
   logic [P_W-1:0] dd_ff;
   logic           keep;
   logic [S_W-1:0] ksum_ff;
   logic [N_W-1:0] kn_ff;

   assign nx_w = S_W'(n_ff) * S_W'(rd_data_ff);
   assign dd_w = P_W'(d_ff) * P_W'(d_ff);
   assign keep = vd_ff && ((L_W'(dd_ff) << 2) < lim_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_keep_ff <= 1'b0;
         vb_ff       <= 1'b0;
         vc_ff       <= 1'b0;
         vd_ff       <= 1'b0;
      end else begin
         tag_keep_ff <= cmd.rd_keep;
         vb_ff       <= tag_keep_ff && x_nz;
         vc_ff       <= vb_ff;
         vd_ff       <= vc_ff;
      end
   end

   always_ff @(posedge clock) begin
      xb_ff <= rd_data_ff;
      nx_ff <= nx_w;
      xc_ff <= xb_ff;
      d_ff  <= (nx_ff >= s_ff) ? (nx_ff - s_ff) : (s_ff - nx_ff);
      xd_ff <= xc_ff;
      dd_ff <= dd_w;
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_keep) begin
         ksum_ff <= '0;
         kn_ff   <= '0;
      end else if (keep) begin
         ksum_ff <= ksum_ff + S_W'(xd_ff);
         kn_ff   <= kn_ff + 1'b1;
      end
   end

   // restoring divider, one quotient bit per step
   logic [S_W-1:0] dvd_ff;
   logic [N_W-1:0] rem_ff;
   logic [N_W:0]   rem_sh;
   logic           q_bit;
   logic [N_W:0]   rem_nx;

   assign rem_sh = {rem_ff, dvd_ff[S_W-1]};
   assign q_bit  = (rem_sh >= {1'b0, kn_ff});
   assign rem_nx = q_bit ? (rem_sh - {1'b0, kn_ff}) : rem_sh;

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         dvd_ff <= ksum_ff;
         rem_ff <= '0;
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[S_W-2:0], q_bit};
         rem_ff <= rem_nx[N_W-1:0];
      end
   end

   // output register
   logic signed [scta_pkg::MEAN_W-1:0] mean_w;
   scta_pkg::rsp_type                  rsp_ff;

   assign mean_w = (kn_ff == '0) ? '1 : $signed(scta_pkg::MEAN_W'(dvd_ff));

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_ff.clipped_mean <= mean_w;
         rsp_ff.used_count   <= scta_pkg::COUNT_W'(n_ff);
         rsp_ff.kept_count   <= scta_pkg::COUNT_W'(kn_ff);
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* tb/sv/clipped_mean_checker.sv */
`timescale 1ns / 1ps

module clipped_mean_checker #(
   parameter int CHANNELS  = 14,
   parameter int HITS_USED = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  scta_pkg::req_type               req_data,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  scta_pkg::rsp_type               rsp_data,
   input  logic                            csr_we,
   input  logic [scta_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [scta_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fault_count,
   output int                              waiting_count,
   output int                              result_count
);

   logic [scta_pkg::TIME_BITS-1:0] chan_time [CHANNELS];
   logic [scta_pkg::TIME_BITS-1:0] win_lo;
   logic [scta_pkg::TIME_BITS-1:0] win_hi;
   scta_pkg::rsp_type              expected_means [$];

   // Mean of the selected times that lie strictly within 1.5 sigma, compared in
   // squared integers: 4(nx-S)^2 < 9(nQ-S^2).
   function automatic scta_pkg::rsp_type clip_event_mean();
      longint unsigned n, s, q, x, d, spread, kept_sum, kept_n;
      scta_pkg::rsp_type r;
      n        = 0;
      s        = 0;
      q        = 0;
      kept_sum = 0;
      kept_n   = 0;
      for (int i = 0; i < CHANNELS; i++) begin
         x = chan_time[i];
         if (x != 0) begin
            s += x;
            q += x * x;
            n++;
         end
      end
      spread = n * q - s * s;
      for (int i = 0; i < CHANNELS; i++) begin
         x = chan_time[i];
         d = (n * x >= s) ? n * x - s : s - n * x;
         if (x != 0 && 4 * d * d < 9 * spread) begin
            kept_sum += x;
            kept_n++;
         end
      end
      if (kept_n != 0)
         r.clipped_mean = scta_pkg::MEAN_W'(kept_sum / kept_n);
      else
         r.clipped_mean = '1;
      r.used_count = scta_pkg::COUNT_W'(n);
      r.kept_count = scta_pkg::COUNT_W'(kept_n);
      return r;
   endfunction

   task automatic flag_fault(string what);
      fault_count++;
      if (fault_count <= 10)
         $display("[%0t] %s", $realtime, what);
   endtask

   always @(posedge clock) begin : watch
      scta_pkg::req_type hit;
      scta_pkg::rsp_type want;
      scta_pkg::rsp_type got;
      if (reset) begin
         win_lo = scta_pkg::WINDOW_LOW_RESET;
         win_hi = scta_pkg::WINDOW_HIGH_RESET;
         for (int i = 0; i < CHANNELS; i++)
            chan_time[i] = '0;
         expected_means.delete();
         fault_count  = 0;
         result_count = 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == scta_pkg::REG_WINDOW_LOW)
               win_lo = csr_wdata;
            else if (csr_addr == scta_pkg::REG_WINDOW_HIGH)
               win_hi = csr_wdata;
         end
         if (req_valid && req_ready) begin
            hit = req_data;
            if (hit.channel < CHANNELS && hit.hit_index < HITS_USED &&
                hit.hit_time >= win_lo && hit.hit_time <= win_hi)
               chan_time[hit.channel] = hit.hit_time;
            // close the event and clear the per-channel store
            if (hit.event_end) begin
               expected_means = {expected_means, clip_event_mean()};
               for (int i = 0; i < CHANNELS; i++)
                  chan_time[i] = '0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_data;
            result_count++;
            if (expected_means.size() == 0) begin
               flag_fault($sformatf("result with no event pending: mean %0d used %0d kept %0d",
                                    got.clipped_mean, got.used_count, got.kept_count));
            end else begin
               want = expected_means.pop_front();
               if (got.clipped_mean !== want.clipped_mean ||
                   got.used_count !== want.used_count ||
                   got.kept_count !== want.kept_count)
                  flag_fault($sformatf({"event result %0d: expected mean %0d used %0d kept %0d,",
                                        " got mean %0d used %0d kept %0d"},
                                       result_count, want.clipped_mean, want.used_count,
                                       want.kept_count, got.clipped_mean, got.used_count,
                                       got.kept_count));
            end
         end
      end
      waiting_count = expected_means.size();
   end

endmodule

/* tb/sv/tb_sigma_clipped_clock_time_average.sv */
`timescale 1ns / 1ps

module tb_sigma_clipped_clock_time_average;

   logic                            clock     = 1'b0;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   scta_pkg::req_type               req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b1;
   scta_pkg::rsp_type               rsp_data;
   logic                            csr_we    = 1'b0;
   logic [scta_pkg::CSR_ADDR_W-1:0] csr_addr  = scta_pkg::REG_WINDOW_LOW;
   logic [scta_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int fault_count;
   int waiting_count;
   int result_count;
   int hits_sent     = 0;
   int settings_done = 0;
   int gap_odds      = 2;
   int stall_odds    = 2;
   int stall_left    = 0;
   bit calm          = 1'b0;
   int cur_lo        = 0;
   int cur_hi        = 65535;

   always #10 clock = ~clock;

   sigma_clipped_clock_time_average u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   clipped_mean_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_data      (rsp_data),
      .csr_we        (csr_we),
      .csr_addr      (csr_addr),
      .csr_wdata     (csr_wdata),
      .fault_count   (fault_count),
      .waiting_count (waiting_count),
      .result_count  (result_count)
   );

   // Random result-side backpressure in bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (!calm && stall_odds > 0 && $urandom_range(1, 8) <= stall_odds) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic scta_pkg::req_type make_hit(int ch, int idx, int t, bit last);
      scta_pkg::req_type h;
      h.channel   = scta_pkg::CHAN_W'(ch);
      h.hit_index = scta_pkg::HIT_W'(idx);
      h.hit_time  = scta_pkg::TIME_BITS'(t);
      h.event_end = last;
      return h;
   endfunction

   // Called at a falling edge; returns at a falling edge.
   task automatic send_hit(scta_pkg::req_type h);
      req_valid <= 1'b1;
      req_data  <= h;
      do
         @(posedge clock);
      while (!req_ready);
      @(negedge clock);
      hits_sent++;
      if (!calm && gap_odds > 0 && $urandom_range(1, 8) <= gap_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   // Drop valid, drain all pending results, then let the pipeline go quiet.
   task automatic settle();
      req_valid <= 1'b0;
      do
         @(negedge clock);
      while (waiting_count != 0);
      repeat (70) @(negedge clock);
   endtask

   task automatic set_window(int lo, int hi);
      settle();
      csr_we    <= 1'b1;
      csr_addr  <= scta_pkg::REG_WINDOW_LOW;
      csr_wdata <= scta_pkg::CSR_DATA_W'(lo);
      @(negedge clock);
      csr_addr  <= scta_pkg::REG_WINDOW_HIGH;
      csr_wdata <= scta_pkg::CSR_DATA_W'(hi);
      @(negedge clock);
      csr_we    <= 1'b0;
      cur_lo = lo;
      cur_hi = hi;
      settings_done++;
   endtask

   // One event: clustered times on a random set of channels, in index order,
   // with outliers, noise hits and the odd truncated event mixed in.
   task automatic send_event(int noise_pct);
      scta_pkg::req_type hits [$];
      scta_pkg::req_type h;
      int center, spread, fill, reps, base, t, cut;
      center = (cur_lo <= cur_hi) ? $urandom_range(cur_lo, cur_hi) : $urandom_range(0, 65535);
      case ($urandom_range(0, 9))
         0: spread = 0;
         1, 2, 3, 4, 5: spread = $urandom_range(1, 60);
         default: spread = $urandom_range(1, 3000);
      endcase
      fill = $urandom_range(10, 100);
      for (int ch = 0; ch < 14; ch++) begin
         if ($urandom_range(0, 99) < fill) begin
            reps = $urandom_range(1, 3);
            base = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 15) : $urandom_range(0, 4);
            for (int r = 0; r < reps; r++) begin
               if ($urandom_range(0, 99) < 8)
                  t = $urandom_range(0, 65535);
               else
                  t = center + int'($urandom_range(0, 2 * spread)) - spread;
               if (t < 0)
                  t = 0;
               if (t > 65535)
                  t = 65535;
               hits = {hits, make_hit(ch, base + r, t, 1'b0)};
            end
         end
         if ($urandom_range(0, 99) < noise_pct)
            hits = {hits, make_hit($urandom_range(0, 15), $urandom_range(0, 15),
                                   $urandom_range(0, 65535), 1'b0)};
      end
      // truncate now and then so the end mark lands mid-stream
      if (hits.size() > 1 && $urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, hits.size());
         while (hits.size() > cut)
            void'(hits.pop_back());
      end
      if (hits.size() == 0)
         hits = {hits, make_hit($urandom_range(0, 15), $urandom_range(0, 15),
                                $urandom_range(0, 65535), 1'b0)};
      h = hits.pop_back();
      h.event_end = 1'b1;
      hits = {hits, h};
      foreach (hits[i])
         send_hit(hits[i]);
   endtask

   initial begin
      int phase, n_ev, lo, hi, noise_pct;
      bit narrow;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty event, equal values, extremes and ignored hits, outlier.
      send_hit(make_hit(15, 0, 1234, 1'b1));
      send_hit(make_hit(0, 0, 500, 1'b0));
      send_hit(make_hit(1, 3, 500, 1'b0));
      send_hit(make_hit(2, 7, 500, 1'b1));
      send_hit(make_hit(0, 0, 65535, 1'b0));
      send_hit(make_hit(13, 7, 65535, 1'b0));
      send_hit(make_hit(1, 0, 1, 1'b0));
      send_hit(make_hit(14, 0, 3000, 1'b0));
      send_hit(make_hit(2, 8, 3000, 1'b0));
      send_hit(make_hit(3, 0, 300, 1'b0));
      send_hit(make_hit(3, 1, 0, 1'b0));
      send_hit(make_hit(4, 15, 9, 1'b0));
      send_hit(make_hit(5, 0, 100, 1'b0));
      send_hit(make_hit(5, 1, 200, 1'b0));
      send_hit(make_hit(6, 2, 210, 1'b0));
      send_hit(make_hit(7, 0, 190, 1'b0));
      send_hit(make_hit(15, 15, 65535, 1'b1));
      send_hit(make_hit(8, 0, 1000, 1'b0));
      send_hit(make_hit(9, 0, 1002, 1'b0));
      send_hit(make_hit(10, 0, 998, 1'b0));
      send_hit(make_hit(11, 0, 60000, 1'b1));

      phase = 0;
      while (hits_sent < 1720) begin
         narrow = 1'b0;
         case (phase % 8)
            0: begin lo = 0; hi = 65535; end
            1: begin
               lo = $urandom_range(0, 30000);
               hi = lo + $urandom_range(100, 35000);
            end
            2: begin lo = 0; hi = 0; narrow = 1'b1; end
            3: begin
               lo = $urandom_range(1000, 60000);
               hi = lo + $urandom_range(0, 300);
            end
            4: begin lo = 65535; hi = 65535; narrow = 1'b1; end
            5: begin
               lo = $urandom_range(20000, 65535);
               hi = $urandom_range(0, lo - 1);
               narrow = 1'b1;
            end
            6: begin lo = 1; hi = 65535; end
            default: begin lo = 0; hi = 32767; end
         endcase
         set_window(lo, hi);
         gap_odds   = $urandom_range(0, 3);
         stall_odds = $urandom_range(0, 3);
         noise_pct  = $urandom_range(0, 20);
         n_ev = narrow ? $urandom_range(2, 4) : $urandom_range(4, 14);
         repeat (n_ev) begin
            send_event(noise_pct);
            calm = (hits_sent >= 1450);
         end
         phase++;
      end

      settle();
      $display("Sent %0d hits under %0d window settings; checked %0d event results.",
               hits_sent, settings_done, result_count);
      if (fault_count == 0 && waiting_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
